>>> hw/rtl/dcs_pkg.sv
// Shared constants, types and codes for the difference constraint store.
package dcs_pkg;

  localparam int MAX_VARS    = 64;
  localparam int WEIGHT_BITS = 32;
  localparam int VB          = $clog2(MAX_VARS);
  localparam int CB          = $clog2(MAX_VARS + 1);
  localparam int AB          = 2 * VB;
  localparam int PB          = WEIGHT_BITS + 2;
  localparam int SB          = PB + 2;

  localparam logic [WEIGHT_BITS-1:0] INF_W = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic [WEIGHT_BITS-1:0] NEG_INF_W = {1'b1, {(WEIGHT_BITS-2){1'b0}}, 1'b1};
  localparam logic [WEIGHT_BITS-1:0] MIN_W = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_NEW  = 2'd0,
    OP_ADD  = 2'd1,
    OP_DROP = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INCONS  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_NV, S_ADD_RD, S_ADD_CHK, S_ADD_INIT, S_LOOP,
    S_STEP, S_SCAN, S_DROP, S_RD1, S_RD2, S_RD3, S_DONE
  } state_t;

  typedef struct packed {
    logic          upd;
    logic          lower;
    logic [PB-1:0] gnew;
  } relax_t;

  function automatic logic [SB-1:0] sx_p(input logic [PB-1:0] v);
    return {{(SB-PB){v[PB-1]}}, v};
  endfunction

  function automatic logic [SB-1:0] sx_w(input logic [WEIGHT_BITS-1:0] v);
    return {{(SB-WEIGHT_BITS){v[WEIGHT_BITS-1]}}, v};
  endfunction

endpackage

>>> hw/rtl/dcs_ram.sv
// Generic single write port, single read port RAM with registered read.
module dcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/dcs_relax.sv
// Edge relaxation of one gamma entry and running minimum compare.
module dcs_relax (
  input  logic [dcs_pkg::PB-1:0]          newpot,
  input  logic [dcs_pkg::WEIGHT_BITS-1:0] edge_w,
  input  logic [dcs_pkg::PB-1:0]          pot_e,
  input  logic [dcs_pkg::PB-1:0]          gam_old,
  input  logic                            elig,
  input  logic [dcs_pkg::PB-1:0]          mn,
  output dcs_pkg::relax_t                 rr
);
  import dcs_pkg::*;

  logic [SB-1:0] sum;
  logic [PB-1:0] t;
  logic          take;

  always_comb begin
    sum  = sx_p(newpot) + sx_w(edge_w) - sx_p(pot_e);
    t    = sum[PB-1:0];
    take = elig && (edge_w != INF_W) && ($signed(t) < $signed(gam_old));
    rr.upd   = take;
    rr.gnew  = take ? t : gam_old;
    rr.lower = $signed(rr.gnew) < $signed(mn);
  end
endmodule

>>> hw/rtl/difference_constraint_store.sv
// Top level: sequencer of the difference constraint store over its RAMs.
//
// Input channel in_valid/in_ready carries opcode, var_x, var_y, weight; the
// output channel out_valid/out_ready carries status, new_index, lower_bound,
// upper_bound and is_fixed, one result transaction per input transaction.
// One transaction is processed at a time; in_ready is high while the
// sequencer is idle, also while a finished result waits in the output
// register. A repairing add runs up to n relaxation steps for n variables
// in use, each a scan over one bound matrix row (one read per cycle of the
// matrix, potential and gamma RAMs). The next transaction can be taken from
// the cycle after a result is registered. After reset the S_INIT state
// seeds the reference entries before the first transaction is taken. When
// the receiver stalls, a finished result stays in the output register and
// the next transaction may still be taken and processed; its result then
// waits in the sequencer until the output register frees.
module difference_constraint_store (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [dcs_pkg::VB-1:0]          var_x,
  input  logic [dcs_pkg::VB-1:0]          var_y,
  input  logic [dcs_pkg::WEIGHT_BITS-1:0] weight,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [dcs_pkg::VB-1:0]          new_index,
  output logic [dcs_pkg::WEIGHT_BITS-1:0] lower_bound,
  output logic [dcs_pkg::WEIGHT_BITS-1:0] upper_bound,
  output logic                            is_fixed
);
  import dcs_pkg::*;

  state_t state, state_next;

  op_t                  op;
  logic [VB-1:0]        x, y, cur, nxt, p_e, id;
  logic [WEIGHT_BITS-1:0] d, lo;
  logic [CB-1:0]        used, steps, e_rd;
  logic [CB:0]          j;
  logic                 p_vld;
  logic [PB-1:0]        mn, gx, newpot, potx;
  logic [MAX_VARS-1:0]  settled, gvalid;

  status_t              res_status;
  logic [VB-1:0]        res_index;
  logic [WEIGHT_BITS-1:0] res_lo, res_hi;

  logic                 bm_we, pot_we, gam_we;
  logic [AB-1:0]        bm_waddr, bm_raddr;
  logic [WEIGHT_BITS-1:0] bm_wdata, bm_rd;
  logic [VB-1:0]        pot_waddr, pot_raddr, gam_waddr, gam_raddr;
  logic [PB-1:0]        pot_wdata, pot_rd, gam_wdata, gam_rd;

  logic [SB-1:0]        init_s, step_s;
  logic [PB-1:0]        init_w, step_pot;
  logic [VB-1:0]        jh;
  logic                 x_ok, y_ok, loop_go, scan_end, out_free;
  relax_t               rr;

  dcs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VARS * MAX_VARS)) u_bm (
    .clk, .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata), .raddr(bm_raddr), .rdata(bm_rd)
  );
  dcs_ram #(.WIDTH(PB), .DEPTH(MAX_VARS)) u_pot (
    .clk, .we(pot_we), .waddr(pot_waddr), .wdata(pot_wdata), .raddr(pot_raddr), .rdata(pot_rd)
  );
  dcs_ram #(.WIDTH(PB), .DEPTH(MAX_VARS)) u_gam (
    .clk, .we(gam_we), .waddr(gam_waddr), .wdata(gam_wdata), .raddr(gam_raddr), .rdata(gam_rd)
  );

  dcs_relax u_relax (
    .newpot (newpot),
    .edge_w (bm_rd),
    .pot_e  (pot_rd),
    .gam_old(gvalid[p_e] ? gam_rd : '0),
    .elig   ((p_e != cur) && !settled[p_e]),
    .mn     (mn),
    .rr     (rr)
  );

  always_comb begin
    x_ok     = CB'(x) < used;
    y_ok     = CB'(y) < used;
    id       = used[VB-1:0];
    jh       = j[VB:1];
    init_s   = sx_p(potx) + sx_w(d) - sx_p(pot_rd);
    init_w   = init_s[PB-1:0];
    step_s   = sx_p(pot_rd) + sx_p(mn);
    step_pot = step_s[PB-1:0];
    loop_go  = mn[PB-1] && (gx == '0) && (steps < used);
    scan_end = (e_rd == used) && !p_vld;
    out_free = !out_valid || out_ready;
    in_ready = (state == S_IDLE);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(opcode))
            OP_NEW:  state_next = S_NV;
            OP_ADD:  state_next = S_ADD_RD;
            OP_DROP: state_next = S_DROP;
            default: state_next = S_RD1;
          endcase
        end
      end
      S_NV: begin
        if (used == CB'(MAX_VARS) || j == {1'b0, id, 1'b0}) state_next = S_DONE;
      end
      S_ADD_RD:  state_next = (x_ok && y_ok) ? S_ADD_CHK : S_DONE;
      S_ADD_CHK: begin
        if ($signed(d) >= $signed(bm_rd) || d == NEG_INF_W) state_next = S_DONE;
        else state_next = S_ADD_INIT;
      end
      S_ADD_INIT: state_next = init_s[SB-1] ? S_LOOP : S_DONE;
      S_LOOP:     state_next = loop_go ? S_STEP : S_DONE;
      S_STEP:     state_next = S_SCAN;
      S_SCAN:     if (scan_end) state_next = S_LOOP;
      S_DROP:     state_next = S_DONE;
      S_RD1:      state_next = x_ok ? S_RD2 : S_DONE;
      S_RD2:      state_next = S_RD3;
      S_RD3:      state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_INIT;
    endcase
  end

  always_comb begin
    bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0; bm_raddr = '0;
    pot_we = 1'b0; pot_waddr = '0; pot_wdata = '0; pot_raddr = '0;
    gam_we = 1'b0; gam_waddr = '0; gam_wdata = '0; gam_raddr = '0;
    case (state)
      S_INIT: begin
        bm_we = 1'b1;
        pot_we = 1'b1;
      end
      S_NV: begin
        if (used != CB'(MAX_VARS)) begin
          bm_we = 1'b1;
          if (!j[0]) begin
            bm_waddr = {id, jh};
            bm_wdata = (jh == id) ? '0 : INF_W;
          end else begin
            bm_waddr = {jh, id};
            bm_wdata = INF_W;
          end
          pot_we    = (j == '0);
          pot_waddr = id;
        end
      end
      S_ADD_RD: begin
        bm_raddr  = {x, y};
        pot_raddr = x;
      end
      S_ADD_CHK: begin
        bm_we     = !($signed(d) >= $signed(bm_rd)) && (d != NEG_INF_W);
        bm_waddr  = {x, y};
        bm_wdata  = d;
        pot_raddr = y;
      end
      S_ADD_INIT: begin
        gam_we    = init_s[SB-1];
        gam_waddr = y;
        gam_wdata = init_w;
      end
      S_LOOP: pot_raddr = cur;
      S_STEP: begin
        pot_we    = 1'b1;
        pot_waddr = cur;
        pot_wdata = step_pot;
      end
      S_SCAN: begin
        bm_raddr  = {cur, e_rd[VB-1:0]};
        pot_raddr = e_rd[VB-1:0];
        gam_raddr = e_rd[VB-1:0];
        gam_we    = p_vld && rr.upd;
        gam_waddr = p_e;
        gam_wdata = rr.gnew;
      end
      S_DROP: begin
        bm_we    = x_ok;
        bm_waddr = {x, {VB{1'b0}}};
        bm_wdata = INF_W;
      end
      S_RD1: bm_raddr = {{VB{1'b0}}, x};
      S_RD2: bm_raddr = {x, {VB{1'b0}}};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      used      <= CB'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid   <= 1'b1;
        status      <= res_status;
        new_index   <= res_index;
        lower_bound <= res_lo;
        upper_bound <= res_hi;
        is_fixed    <= (op == OP_READ) && (res_status == ST_OK) && (res_lo == res_hi);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_NV && used != CB'(MAX_VARS) && j == {1'b0, id, 1'b0})
        used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op <= op_t'(opcode);
        x  <= var_x;
        y  <= var_y;
        d  <= (weight == MIN_W) ? NEG_INF_W : weight;
        j  <= '0;
        res_status <= ST_OK;
        res_index  <= '0;
        res_lo     <= '0;
        res_hi     <= '0;
      end
      S_NV: begin
        j <= j + 1'b1;
        if (used == CB'(MAX_VARS)) res_status <= ST_FULL;
        else res_index <= id;
      end
      S_ADD_RD: if (!(x_ok && y_ok)) res_status <= ST_RANGE;
      S_ADD_CHK: begin
        potx <= pot_rd;
        if (!($signed(d) >= $signed(bm_rd)) && d == NEG_INF_W) res_status <= ST_INCONS;
      end
      S_ADD_INIT: begin
        gvalid  <= {{(MAX_VARS-1){1'b0}}, 1'b1} << y;
        settled <= '0;
        mn      <= init_w;
        cur     <= y;
        gx      <= (x == y) ? init_w : '0;
        steps   <= '0;
      end
      S_LOOP: begin
        if (loop_go) steps <= steps + 1'b1;
        else res_status <= gx[PB-1] ? ST_INCONS : ST_OK;
      end
      S_STEP: begin
        newpot       <= step_pot;
        settled[cur] <= 1'b1;
        gvalid[cur]  <= 1'b0;
        mn           <= '0;
        nxt          <= cur;
        e_rd         <= '0;
        p_vld        <= 1'b0;
      end
      S_SCAN: begin
        if (e_rd < used) begin
          e_rd  <= e_rd + 1'b1;
          p_vld <= 1'b1;
          p_e   <= e_rd[VB-1:0];
        end else begin
          p_vld <= 1'b0;
        end
        if (p_vld) begin
          if (rr.lower) begin
            mn  <= rr.gnew;
            nxt <= p_e;
          end
          if (p_e == x) gx <= rr.gnew;
          if (rr.upd) gvalid[p_e] <= 1'b1;
        end
        if (scan_end) cur <= nxt;
      end
      S_DROP: if (!x_ok) res_status <= ST_RANGE;
      S_RD1:  if (!x_ok) res_status <= ST_RANGE;
      S_RD2: begin
        lo     <= bm_rd;
        res_lo <= '0 - bm_rd;
      end
      S_RD3: res_hi <= bm_rd;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used >= CB'(1) && used <= CB'(MAX_VARS)) else $error("used count out of range");
  a_scan_settled: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> settled[cur]) else $error("scanning row of unsettled variable");
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> steps <= used) else $error("relaxation ran past variable count");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE)) else $error("result without completion");
  a_read_lo: assert property (@(posedge clk) disable iff (rst)
    state == S_RD3 |-> res_lo == '0 - lo) else $error("lower bound capture mismatch");
`endif
endmodule
